>>> sv/rti_pkg.sv
// Shared widths, payload types and the coordinate saturation function.
package rti_pkg;

  localparam int CW        = 20;           // one packed component
  localparam int VW        = 3 * CW;       // packed xyz vector
  localparam int DW        = CW + 1;       // difference of two components
  localparam int MW        = 2 * DW;       // 2x2 minor
  localparam int DETW      = 64;           // 3x3 determinants, signed
  localparam int UW        = DETW - 1;     // determinant magnitude
  localparam int QW        = 32;           // quotient bits per lane
  localparam int NW        = UW + QW;      // divider numerator
  localparam int NLANE     = 4;            // t plus three normal components
  localparam int CH        = 21;           // chunk of a wide multiplicand
  localparam int NCH       = 3;            // chunks covering UW bits
  localparam int NUMW      = 84;           // normal numerator, signed
  localparam int MDW       = 16;           // min_distance width
  localparam int DMW       = UW + MDW;     // D * min_distance
  localparam int DIST_FRAC = 16;
  localparam int TSW       = DETW + DIST_FRAC;
  localparam int CMPW      = TSW + 1;
  localparam int SATW      = 40;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;

  typedef struct packed {
    logic signed [DETW-1:0] dd;
    logic signed [DETW-1:0] bd;
    logic signed [DETW-1:0] gd;
    logic signed [DETW-1:0] td;
  } det_t;

  typedef struct packed {
    coord_t [2:0] o;
    coord_t [2:0] dv;
    coord_t [2:0] na;
  } side_t;

  typedef struct packed {
    diff_t [2:0] dnb;
    diff_t [2:0] dnc;
  } ndiff_t;

  typedef struct packed {
    logic       hit;
    logic       sat;
    logic [2:0] neg;
    side_t      side;
  } dtag_t;

  typedef struct packed {
    logic          hit;
    logic [QW-1:0] distance;
    logic [VW-1:0] hit_pos;
    logic [VW-1:0] surface_normal;
  } res_t;

  function automatic logic [CW-1:0] sat_coord(input logic signed [SATW-1:0] v);
    logic [SATW-CW:0] top;
    top = v[SATW-1:CW-1];
    if (top == '0 || top == '1) begin
      return v[CW-1:0];
    end else if (v[SATW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

endpackage

>>> sv/rti_det.sv
// Determinant front end: edge differences, minors and the four 3x3 determinants.
module rti_det import rti_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [VW-1:0] org,
  input  logic [VW-1:0] dir,
  input  logic [VW-1:0] va,
  input  logic [VW-1:0] vb,
  input  logic [VW-1:0] vc,
  input  logic [VW-1:0] na,
  input  logic [VW-1:0] nb,
  input  logic [VW-1:0] nc,
  output logic          out_v,
  output det_t          det,
  output side_t         side,
  output ndiff_t        nd
);

  logic [4:0] v_r;

  // stage 1: columns of the system, per axis
  logic signed [DW-1:0] e1_r [3], e2_r [3], e3_r [3], e4_r [3];
  logic signed [DW-1:0] e1_nxt [3], e2_nxt [3], e3_nxt [3], e4_nxt [3];
  side_t  sd_nxt;
  ndiff_t nd_nxt;

  // stage 2: minors m n p q s r
  logic signed [MW-1:0] mn_r [6];
  logic signed [MW-1:0] ml [6], mr [6];
  logic signed [DW-1:0] a2_r, b2_r, c2_r, d2_r;

  // stage 3: split products
  logic signed [DW-1:0]   bx [12];
  logic signed [MW-1:0]   by [12];
  logic signed [MW:0]     pl_r [12];
  logic signed [MW-1:0]   ph_r [12];
  logic signed [MW:0]     pl_nxt [12];
  logic signed [MW-1:0]   ph_nxt [12];

  // stage 4: full products
  logic signed [DETW-1:0] pr_r [12];

  // stage 5: determinants
  det_t det_r;

  side_t  sd_r [5];
  ndiff_t nd_r [5];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      e1_nxt[ax] = DW'($signed(va[ax*CW +: CW])) - DW'($signed(vb[ax*CW +: CW]));
      e2_nxt[ax] = DW'($signed(va[ax*CW +: CW])) - DW'($signed(vc[ax*CW +: CW]));
      e3_nxt[ax] = DW'($signed(dir[ax*CW +: CW]));
      e4_nxt[ax] = DW'($signed(va[ax*CW +: CW])) - DW'($signed(org[ax*CW +: CW]));
      sd_nxt.o[ax]   = org[ax*CW +: CW];
      sd_nxt.dv[ax]  = dir[ax*CW +: CW];
      sd_nxt.na[ax]  = na[ax*CW +: CW];
      nd_nxt.dnb[ax] = DW'($signed(nb[ax*CW +: CW])) - DW'($signed(na[ax*CW +: CW]));
      nd_nxt.dnc[ax] = DW'($signed(nc[ax*CW +: CW])) - DW'($signed(na[ax*CW +: CW]));
    end
  end

  // a=e1[0] e=e1[1] i=e1[2], b=e2[..], c=e3[..], d=e4[..]
  always_comb begin
    ml[0] = e2_r[1] * e3_r[2];  mr[0] = e3_r[1] * e2_r[2];  // m = f*k - g*j
    ml[1] = e4_r[1] * e3_r[2];  mr[1] = e3_r[1] * e4_r[2];  // n = h*k - g*l
    ml[2] = e2_r[1] * e4_r[2];  mr[2] = e4_r[1] * e2_r[2];  // p = f*l - h*j
    ml[3] = e3_r[1] * e1_r[2];  mr[3] = e1_r[1] * e3_r[2];  // q = g*i - e*k
    ml[4] = e1_r[1] * e2_r[2];  mr[4] = e2_r[1] * e1_r[2];  // s = e*j - f*i
    ml[5] = e1_r[1] * e4_r[2];  mr[5] = e4_r[1] * e1_r[2];  // r = e*l - h*i
  end

  always_comb begin
    bx[0]  = a2_r; by[0]  = mn_r[0];
    bx[1]  = b2_r; by[1]  = mn_r[3];
    bx[2]  = c2_r; by[2]  = mn_r[4];
    bx[3]  = d2_r; by[3]  = mn_r[0];
    bx[4]  = b2_r; by[4]  = mn_r[1];
    bx[5]  = c2_r; by[5]  = mn_r[2];
    bx[6]  = a2_r; by[6]  = mn_r[1];
    bx[7]  = d2_r; by[7]  = mn_r[3];
    bx[8]  = c2_r; by[8]  = mn_r[5];
    bx[9]  = a2_r; by[9]  = mn_r[2];
    bx[10] = b2_r; by[10] = mn_r[5];
    bx[11] = d2_r; by[11] = mn_r[4];
    for (int i = 0; i < 12; i++) begin
      pl_nxt[i] = bx[i] * $signed({1'b0, by[i][DW-1:0]});
      ph_nxt[i] = bx[i] * $signed(by[i][MW-1:DW]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ax = 0; ax < 3; ax++) begin
        e1_r[ax] <= e1_nxt[ax];
        e2_r[ax] <= e2_nxt[ax];
        e3_r[ax] <= e3_nxt[ax];
        e4_r[ax] <= e4_nxt[ax];
      end
      for (int i = 0; i < 6; i++) begin
        mn_r[i] <= ml[i] - mr[i];
      end
      a2_r <= e1_r[0];
      b2_r <= e2_r[0];
      c2_r <= e3_r[0];
      d2_r <= e4_r[0];
      for (int i = 0; i < 12; i++) begin
        pl_r[i] <= pl_nxt[i];
        ph_r[i] <= ph_nxt[i];
        pr_r[i] <= (DETW'(ph_r[i]) <<< DW) + DETW'(pl_r[i]);
      end
      det_r.dd <= pr_r[0] + pr_r[1] + pr_r[2];
      det_r.bd <= pr_r[3] - pr_r[4] - pr_r[5];
      det_r.gd <= pr_r[6] + pr_r[7] + pr_r[8];
      det_r.td <= pr_r[9] - pr_r[10] + pr_r[11];
      sd_r[0] <= sd_nxt;
      nd_r[0] <= nd_nxt;
      for (int k = 1; k < 5; k++) begin
        sd_r[k] <= sd_r[k-1];
        nd_r[k] <= nd_r[k-1];
      end
    end
  end

  assign out_v = v_r[4];
  assign det   = det_r;
  assign side  = sd_r[4];
  assign nd    = nd_r[4];

endmodule

>>> sv/rti_test.sv
// Sign fix, hit tests, epsilon compare and normal numerators ahead of the divider.
module rti_test import rti_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_v,
  input  det_t                       det,
  input  side_t                      side,
  input  ndiff_t                     nd,
  input  logic [MDW-1:0]             md,
  output logic                       out_v,
  output logic [NLANE-1:0][NW-1:0]   numer,
  output logic [UW-1:0]              divisor,
  output dtag_t                      tag
);

  logic [4:0] v_r;
  side_t      sd_r [5];

  // T1: normalised determinants
  det_t   n1_r, n1_nxt;
  logic   nz1_r;
  ndiff_t nd1_r;

  // T2: tests and partial products
  logic                    pos2_r, in2_r, sat2_r, nz2_r;
  logic signed [DETW-1:0]  td2_r, dd2_r;
  logic [QW+MDW-1:0]       mdp0_r;
  logic [UW-QW+MDW-1:0]    mdp1_r;
  logic signed [CH+DW:0]   np_r [3][2][NCH];
  logic signed [CH+DW:0]   np_nxt [3][2][NCH];
  logic signed [DETW:0]    sbg, sdd;
  logic signed [TSW-1:0]   tdx, ddx;
  diff_t                   dsel;
  logic [CH-1:0]           chunk;

  // T3
  logic                    hp3_r, sat3_r, above3_r;
  logic signed [DETW-1:0]  td3_r, dd3_r;
  logic signed [NUMW-1:0]  npr_r [3][2];
  logic signed [NUMW-1:0]  npr_nxt [3][2];
  logic [DMW-1:0]          dmd;
  logic signed [CMPW-1:0]  lhs, rhs;

  // T4
  logic                    hit4_r, sat4_r;
  logic signed [DETW-1:0]  dd4_r;
  logic [NW-1:0]           tn4_r;
  logic signed [NUMW-1:0]  num4_r [3];

  // T5
  logic [NLANE-1:0][NW-1:0] numer_r;
  logic [UW-1:0]            dvs_r;
  dtag_t                    tag_r, tag_nxt;
  logic [NLANE-1:0][NW-1:0] numer_nxt;
  logic [NUMW-1:0]          mag;

  // negative D: negate all four, ratios unchanged
  always_comb begin
    if (det.dd[DETW-1]) begin
      n1_nxt.dd = -det.dd;
      n1_nxt.bd = -det.bd;
      n1_nxt.gd = -det.gd;
      n1_nxt.td = -det.td;
    end else begin
      n1_nxt = det;
    end
  end

  always_comb begin
    sbg = (DETW+1)'(n1_r.bd) + (DETW+1)'(n1_r.gd);
    sdd = (DETW+1)'(n1_r.dd);
    tdx = TSW'(n1_r.td);
    ddx = TSW'(n1_r.dd) <<< DIST_FRAC;
    for (int ax = 0; ax < 3; ax++) begin
      for (int t = 0; t < 2; t++) begin
        dsel = (t == 0) ? nd1_r.dnb[ax] : nd1_r.dnc[ax];
        for (int k = 0; k < NCH; k++) begin
          chunk = (t == 0) ? n1_r.bd[k*CH +: CH] : n1_r.gd[k*CH +: CH];
          np_nxt[ax][t][k] = $signed({1'b0, chunk}) * dsel;
        end
      end
    end
  end

  always_comb begin
    dmd = (DMW'(mdp1_r) << QW) + DMW'(mdp0_r);
    lhs = CMPW'($signed({td2_r, {DIST_FRAC{1'b0}}}));
    rhs = $signed(CMPW'(dmd));
    for (int ax = 0; ax < 3; ax++) begin
      for (int t = 0; t < 2; t++) begin
        npr_nxt[ax][t] = '0;
        for (int k = 0; k < NCH; k++) begin
          npr_nxt[ax][t] = npr_nxt[ax][t] + (NUMW'(np_r[ax][t][k]) <<< (CH*k));
        end
      end
    end
  end

  always_comb begin
    numer_nxt[0] = tn4_r;
    tag_nxt.hit  = hit4_r;
    tag_nxt.sat  = sat4_r;
    tag_nxt.side = sd_r[3];
    for (int ax = 0; ax < 3; ax++) begin
      tag_nxt.neg[ax] = num4_r[ax][NUMW-1];
      mag = num4_r[ax][NUMW-1] ? NUMW'(-num4_r[ax]) : NUMW'(num4_r[ax]);
      numer_nxt[ax+1] = NW'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side;
      for (int k = 1; k < 5; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
      // T1
      n1_r  <= n1_nxt;
      nz1_r <= (det.dd != '0);
      nd1_r <= nd;
      // T2
      pos2_r <= !n1_r.bd[DETW-1] && !n1_r.gd[DETW-1];
      in2_r  <= (sbg <= sdd);
      sat2_r <= (tdx >= ddx);
      nz2_r  <= nz1_r;
      td2_r  <= n1_r.td;
      dd2_r  <= n1_r.dd;
      mdp0_r <= n1_r.dd[QW-1:0] * md;
      mdp1_r <= n1_r.dd[UW-1:QW] * md;
      for (int ax = 0; ax < 3; ax++) begin
        for (int t = 0; t < 2; t++) begin
          for (int k = 0; k < NCH; k++) begin
            np_r[ax][t][k] <= np_nxt[ax][t][k];
          end
        end
      end
      // T3
      hp3_r    <= nz2_r && pos2_r && in2_r;
      sat3_r   <= sat2_r;
      above3_r <= (lhs > rhs);
      td3_r    <= td2_r;
      dd3_r    <= dd2_r;
      for (int ax = 0; ax < 3; ax++) begin
        for (int t = 0; t < 2; t++) begin
          npr_r[ax][t] <= npr_nxt[ax][t];
        end
      end
      // T4
      hit4_r <= hp3_r && above3_r;
      sat4_r <= sat3_r;
      dd4_r  <= dd3_r;
      tn4_r  <= sat3_r ? '0 : NW'({td3_r[UW-1:0], {DIST_FRAC{1'b0}}});
      for (int ax = 0; ax < 3; ax++) begin
        num4_r[ax] <= npr_r[ax][0] + npr_r[ax][1];
      end
      // T5
      numer_r <= numer_nxt;
      dvs_r   <= dd4_r[UW-1:0];
      tag_r   <= tag_nxt;
    end
  end

  assign out_v   = v_r[4];
  assign numer   = numer_r;
  assign divisor = dvs_r;
  assign tag     = tag_r;

endmodule

>>> sv/rti_div.sv
// Pipelined restoring divider, one quotient bit per stage, four lanes sharing one divisor.
module rti_div import rti_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [NLANE-1:0][NW-1:0]  numer,
  input  logic [UW-1:0]             divisor,
  input  dtag_t                     tag,
  output logic                      out_v,
  output logic [NLANE-1:0][QW-1:0]  quo,
  output logic [NLANE-1:0]          remnz,
  output dtag_t                     tag_o
);

  logic [QW-1:0] v_r;
  logic [UW-1:0] rem_r   [QW][NLANE];
  logic [QW-1:0] low_r   [QW][NLANE];
  logic [QW-1:0] q_r     [QW][NLANE];
  logic [UW-1:0] rem_nxt [QW][NLANE];
  logic [QW-1:0] low_nxt [QW][NLANE];
  logic [QW-1:0] q_nxt   [QW][NLANE];
  logic [UW-1:0] dvs_r   [QW];
  dtag_t         tag_r   [QW];

  always_comb begin
    logic [UW:0]   r2;
    logic [UW-1:0] rin;
    logic [UW-1:0] din;
    logic [QW-1:0] lin;
    logic [QW-1:0] qin;
    logic          ge;
    for (int s = 0; s < QW; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        if (s == 0) begin
          rin = numer[l][NW-1:QW];
          lin = numer[l][QW-1:0];
          qin = '0;
          din = divisor;
        end else begin
          rin = rem_r[s-1][l];
          lin = low_r[s-1][l];
          qin = q_r[s-1][l];
          din = dvs_r[s-1];
        end
        r2 = {rin, lin[QW-1]};
        ge = (r2 >= {1'b0, din});
        rem_nxt[s][l] = ge ? UW'(r2 - {1'b0, din}) : r2[UW-1:0];
        low_nxt[s][l] = {lin[QW-2:0], 1'b0};
        q_nxt[s][l]   = {qin[QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvs_r[0] <= divisor;
      tag_r[0] <= tag;
      for (int s = 1; s < QW; s++) begin
        dvs_r[s] <= dvs_r[s-1];
        tag_r[s] <= tag_r[s-1];
      end
      for (int s = 0; s < QW; s++) begin
        for (int l = 0; l < NLANE; l++) begin
          rem_r[s][l] <= rem_nxt[s][l];
          low_r[s][l] <= low_nxt[s][l];
          q_r[s][l]   <= q_nxt[s][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      quo[l]   = q_r[QW-1][l];
      remnz[l] = (rem_r[QW-1][l] != '0);
    end
  end

  assign out_v = v_r[QW-1];
  assign tag_o = tag_r[QW-1];

endmodule

>>> sv/rti_post.sv
// Result assembly: distance saturation, hit point and interpolated normal.
module rti_post import rti_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [NLANE-1:0][QW-1:0]  quo,
  input  logic [NLANE-1:0]          remnz,
  input  dtag_t                     tag,
  output logic                      out_v,
  output res_t                      res
);

  logic [1:0] v_r;

  // P1
  logic                    hit1_r;
  logic [QW-1:0]           t1_r;
  logic signed [QW+CW:0]   prod_r [3];
  logic signed [QW+CW:0]   prod_nxt [3];
  logic [CW-1:0]           nm1_r [3];
  logic [CW-1:0]           nm_nxt [3];
  coord_t                  o1_r [3];
  logic [QW-1:0]           tsel;
  logic signed [QW+1:0]    qs;
  logic signed [SATW-1:0]  nv;

  // P2
  res_t                    res_r, res_nxt;
  logic signed [SATW-1:0]  hv;

  always_comb begin
    tsel = tag.sat ? '1 : quo[0];
    for (int ax = 0; ax < 3; ax++) begin
      prod_nxt[ax] = $signed({1'b0, tsel}) * $signed(tag.side.dv[ax]);
      // floor division of a negative numerator rounds away from zero
      qs = $signed({2'b00, quo[ax+1]});
      if (tag.neg[ax]) begin
        qs = -(qs + (QW+2)'(remnz[ax+1]));
      end
      nv = SATW'($signed(tag.side.na[ax])) + SATW'(qs);
      nm_nxt[ax] = sat_coord(nv);
    end
  end

  always_comb begin
    res_nxt.hit            = hit1_r;
    res_nxt.distance       = hit1_r ? t1_r : '0;
    res_nxt.hit_pos        = '0;
    res_nxt.surface_normal = '0;
    for (int ax = 0; ax < 3; ax++) begin
      hv = SATW'($signed(o1_r[ax])) + SATW'(prod_r[ax] >>> DIST_FRAC);
      if (hit1_r) begin
        res_nxt.hit_pos[ax*CW +: CW]        = sat_coord(hv);
        res_nxt.surface_normal[ax*CW +: CW] = nm1_r[ax];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit1_r <= tag.hit;
      t1_r   <= tsel;
      for (int ax = 0; ax < 3; ax++) begin
        prod_r[ax] <= prod_nxt[ax];
        nm1_r[ax]  <= nm_nxt[ax];
        o1_r[ax]   <= tag.side.o[ax];
      end
      res_r <= res_nxt;
    end
  end

  assign out_v = v_r[1];
  assign res   = res_r;

endmodule

>>> sv/ray_triangle_intersect_smooth.sv
// Top level: ray / smooth-triangle intersection pipeline with output skid stage.
//
// Takes one ray and one triangle per item and returns one result item for it:
// hit flag, distance t (unsigned Q16.16), hit point (Q12.8 xyz) and the
// barycentric blend of the three vertex normals (Q2.18 xyz, not normalised).
// The system is solved by Cramer's rule in exact integer arithmetic, so the
// hit decision (beta >= 0, gamma >= 0, beta + gamma <= 1, t > min_distance)
// never depends on a rounded quotient; edge and vertex touches count as hits
// and a zero determinant is a miss. On a miss every output field is zero.
// Throughput is one item per clock unless the output stalls. From input to output:
// 5 stages forming the determinants, 5 for the sign fix, tests and normal
// numerators, 32 for the bit-per-stage divider (t and the three normal
// components share it as four lanes), 2 for result assembly, then the output
// register. All stages advance together; when the output is stalled one item
// is parked in a skid register and in_stall rises the next cycle, so nothing
// is lost or repeated. min_distance resets to 1 and is written through the
// cfg_ channel, which is always ready; write it only while the block is idle.
module ray_triangle_intersect_smooth import rti_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [VW-1:0]  in_ray_origin,
  input  logic [VW-1:0]  in_ray_direction,
  input  logic [VW-1:0]  in_vertex_a,
  input  logic [VW-1:0]  in_vertex_b,
  input  logic [VW-1:0]  in_vertex_c,
  input  logic [VW-1:0]  in_normal_a,
  input  logic [VW-1:0]  in_normal_b,
  input  logic [VW-1:0]  in_normal_c,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_hit,
  output logic [QW-1:0]  out_distance,
  output logic [VW-1:0]  out_hit_point,
  output logic [VW-1:0]  out_surface_normal,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [MDW-1:0] cfg_min_distance
);

  logic           en;
  logic [MDW-1:0] md_r;

  logic   det_v;
  det_t   det;
  side_t  side;
  ndiff_t nd;

  logic                     tst_v;
  logic [NLANE-1:0][NW-1:0] numer;
  logic [UW-1:0]            divisor;
  dtag_t                    dtag;

  logic                     div_v;
  logic [NLANE-1:0][QW-1:0] quo;
  logic [NLANE-1:0]         remnz;
  dtag_t                    qtag;

  logic pv;
  res_t pres;

  // output register plus one-entry skid
  logic out_v_r, skid_v_r;
  res_t out_d_r, skid_d_r;

  // whole pipeline moves unless the skid entry is occupied
  assign en        = !skid_v_r;
  assign in_stall  = skid_v_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_r <= MDW'(1);
    end else if (cfg_valid && cfg_ready) begin
      md_r <= cfg_min_distance;
    end
  end

  rti_det u_det (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_valid),
    .org   (in_ray_origin),
    .dir   (in_ray_direction),
    .va    (in_vertex_a),
    .vb    (in_vertex_b),
    .vc    (in_vertex_c),
    .na    (in_normal_a),
    .nb    (in_normal_b),
    .nc    (in_normal_c),
    .out_v (det_v),
    .det   (det),
    .side  (side),
    .nd    (nd)
  );

  rti_test u_test (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (det_v),
    .det     (det),
    .side    (side),
    .nd      (nd),
    .md      (md_r),
    .out_v   (tst_v),
    .numer   (numer),
    .divisor (divisor),
    .tag     (dtag)
  );

  rti_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (tst_v),
    .numer   (numer),
    .divisor (divisor),
    .tag     (dtag),
    .out_v   (div_v),
    .quo     (quo),
    .remnz   (remnz),
    .tag_o   (qtag)
  );

  rti_post u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (div_v),
    .quo   (quo),
    .remnz (remnz),
    .tag   (qtag),
    .out_v (pv),
    .res   (pres)
  );

  // With the skid empty the pipeline is moving, so a valid last stage item
  // leaves this cycle: into the output register if it is free, else the skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      out_v_r  <= skid_v_r || pv;
      skid_v_r <= 1'b0;
    end else if (pv && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      out_d_r <= skid_v_r ? skid_d_r : pres;
    end
    if (out_v_r && out_stall && !skid_v_r) begin
      skid_d_r <= pres;
    end
  end

  assign out_valid          = out_v_r;
  assign out_hit            = out_d_r.hit;
  assign out_distance       = out_d_r.distance;
  assign out_hit_point      = out_d_r.hit_pos;
  assign out_surface_normal = out_d_r.surface_normal;

endmodule
